[rtl/button_click_hold_detector_assert.svh]
// assertion macros shared by the button click/hold detector rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check disabled while reset is asserted
`define BCHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs through reset
`define BCHD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BCHD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCHD_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

[rtl/bchd_pkg.sv]
// types and constants of the button click/hold detector
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int TIME_W      = 32;
  localparam int PIN_W       = 4;
  localparam int CODE_W      = 4;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_BUTTONS = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD  = 2'd2;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] CHECK_PERIOD_RST = 16'd10;
  localparam logic [CFG_W-1:0] CLICK_PERIOD_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_TIME_RST    = 16'd1000;

  localparam logic [CODE_W-1:0] EVT_NONE = 4'd0;

  typedef struct packed {
    logic [CFG_W-1:0] check_period;
    logic [CFG_W-1:0] click_period;
    logic [CFG_W-1:0] hold_time;
  } bchd_cfg_t;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] time_ms;
  } bchd_item_t;

endpackage

[rtl/button_click_hold_detector.sv]
// button click/hold detector: an accepted item is loaded into the input register and
// its result then into the result register; one item per clock while
// out_tready stays high, a stalled result holds both stages
// all button state updates on the edge that registers the item's result
// rst_n is synchronous: clears valids, marks, start times and last check time,
// loads check/click/hold with 10 / 50 / 1000 ms; uses bchd_pkg, bchd_cfg, bchd_eval
`timescale 1ns / 1ps
`include "button_click_hold_detector_assert.svh"

module button_click_hold_detector #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bchd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] time_ms, [35:32] pin_levels
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bchd_pkg::OUT_TDATA_W-1:0] out_tdata,  // [3:0] event_code
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bchd_pkg::CFG_W-1:0]       cfg_data
);
  import bchd_pkg::*;

  bchd_cfg_t         cfg;
  logic              s1_valid_r, s1_valid_nxt;
  bchd_item_t        s1_item_r, s1_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic [CODE_W-1:0] eval_code;
  logic              advance;
  logic              fire;
  logic              in_xfer;

  bchd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_out   (cfg)
  );

  bchd_eval #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (fire),
    .item       (s1_item_r),
    .event_code (eval_code)
  );

  // pipeline flow control
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    if (in_xfer) begin
      s1_item_nxt.time_ms    = in_tdata[TIME_W-1:0];
      s1_item_nxt.pin_levels = in_tdata[TIME_W+PIN_W-1:TIME_W];
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      out_code_nxt  = eval_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_code_r <= out_code_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CODE_W){1'b0}}, out_code_r};

  // checks
  `BCHD_ASSERT(a_stall_blocks_input, clk, rst_n, s1_valid_r && !advance |-> !in_tready, "input taken while the input register is stalled")
  `BCHD_ASSERT(a_result_from_stage, clk, rst_n, $rose(out_tvalid) |-> $past(s1_valid_r), "result appeared without an item in the input register")
  `BCHD_ASSERT_NR(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

[rtl/bchd_cfg.sv]
// configuration register file of the button click/hold detector
// depends on bchd_pkg
`timescale 1ns / 1ps

module bchd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bchd_pkg::CFG_W-1:0]     cfg_data,
  output bchd_pkg::bchd_cfg_t            cfg_out
);
  import bchd_pkg::*;

  bchd_cfg_t cfg_r, cfg_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_out   = cfg_r;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_CHECK: cfg_nxt.check_period = cfg_data;
        CFG_IDX_CLICK: cfg_nxt.click_period = cfg_data;
        CFG_IDX_HOLD:  cfg_nxt.hold_time    = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_period <= CHECK_PERIOD_RST;
      cfg_r.click_period <= CLICK_PERIOD_RST;
      cfg_r.hold_time    <= HOLD_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/bchd_eval.sv]
// per-button state and event evaluation with priority pick
// depends on bchd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "button_click_hold_detector_assert.svh"

module bchd_eval #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bchd_pkg::bchd_cfg_t         cfg,
  input  logic                        fire,
  input  bchd_pkg::bchd_item_t        item,
  output logic [bchd_pkg::CODE_W-1:0] event_code
);
  import bchd_pkg::*;

  logic [TIME_W-1:0]      last_check_r;
  logic [TIME_W-1:0]      start_r   [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] clicked_r;
  logic [NUM_BUTTONS-1:0] held_r;

  logic [TIME_W-1:0]      start_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] clicked_nxt;
  logic [NUM_BUTTONS-1:0] held_nxt;

  logic [TIME_W-1:0]      since_check;
  logic                   due;
  logic [MAX_BUTTONS-1:0] levels_wide;
  logic [NUM_BUTTONS-1:0] pressed;
  logic [TIME_W-1:0]      span      [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ev_click;
  logic [NUM_BUTTONS-1:0] ev_hold;
  logic [NUM_BUTTONS-1:0] blocked;
  logic                   seen;
  logic [CODE_W-1:0]      code;

  // check period gate, wrap-around difference
  assign since_check = item.time_ms - last_check_r;
  assign due         = since_check >= {{(TIME_W-CFG_W){1'b0}}, cfg.check_period};

  // buttons without a pin read a low level, i.e. pressed
  assign levels_wide = {{(MAX_BUTTONS-PIN_W){1'b0}}, item.pin_levels};
  assign pressed     = ~levels_wide[NUM_BUTTONS-1:0];

  // candidate update of every button, independent of the others
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      span[i]        = item.time_ms - start_r[i];
      start_nxt[i]   = start_r[i];
      clicked_nxt[i] = clicked_r[i];
      held_nxt[i]    = held_r[i];
      ev_click[i]    = 1'b0;
      ev_hold[i]     = 1'b0;
      if (pressed[i]) begin
        if (!clicked_r[i] && span[i] >= {{(TIME_W-CFG_W){1'b0}}, cfg.click_period}) begin
          clicked_nxt[i] = 1'b1;
          start_nxt[i]   = item.time_ms;
        end else if (!held_r[i] &&
                     span[i] >= {{(TIME_W-CFG_W){1'b0}}, cfg.hold_time}) begin
          held_nxt[i] = 1'b1;
          ev_hold[i]  = 1'b1;
        end
      end else if (clicked_r[i]) begin
        clicked_nxt[i] = 1'b0;
        if (!held_r[i]) begin
          start_nxt[i] = item.time_ms;
          ev_click[i]  = 1'b1;
        end else begin
          held_nxt[i] = 1'b0;
        end
      end
    end
  end

  // priority pick: the lowest button with an event wins, later ones hold state
  always_comb begin
    seen = 1'b0;
    code = EVT_NONE;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      blocked[i] = seen;
      if (!seen && ev_hold[i]) begin
        code = CODE_W'(NUM_BUTTONS + i + 1);
      end else if (!seen && ev_click[i]) begin
        code = CODE_W'(i + 1);
      end
      seen = seen | ev_hold[i] | ev_click[i];
    end
  end

  assign event_code = due ? code : EVT_NONE;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_check_r <= '0;
      clicked_r    <= '0;
      held_r       <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        start_r[i] <= '0;
      end
    end else if (fire && due) begin
      last_check_r <= item.time_ms;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (!blocked[i]) begin
          start_r[i]   <= start_nxt[i];
          clicked_r[i] <= clicked_nxt[i];
          held_r[i]    <= held_nxt[i];
        end
      end
    end
  end

  // checks
  `BCHD_ASSERT(a_no_check_keeps_time, clk, rst_n, fire && !due |=> $stable(last_check_r), "last check time moved without a due check")
  `BCHD_ASSERT(a_check_takes_time, clk, rst_n, fire && due |=> last_check_r == $past(item.time_ms), "due check did not record the time")
  `BCHD_ASSERT(a_event_needs_check, clk, rst_n, event_code != EVT_NONE |-> due, "event reported outside a due check")

endmodule
